FILE: design/fra_pkg.sv
// shared types, constants and helpers of the fragment reassembly deframer
package fra_pkg;

	localparam int POS_W = 14;
	localparam int LEN_W = 15;
	localparam int TGT_W = 24;
	localparam int ASM_W = 14;
	localparam int DATA_W = 8;
	localparam int TDATA_W = 216;
	localparam int unsigned DEFAULT_BUFFER_BYTES = 8192;

	localparam logic [POS_W-1:0] POS_MAX = 14'd16383;
	localparam logic [LEN_W-1:0] HDR_MIN_BYTES = 15'd34;
	localparam logic [LEN_W-1:0] FULL_HDR_BYTES = 15'd37;

	localparam logic [7:0] MAGIC_C = 8'h43;
	localparam logic [7:0] MAGIC_M = 8'h4d;
	localparam logic [7:0] MAGIC_D = 8'h44;
	localparam logic [7:0] MAGIC_COLON = 8'h3a;

	typedef enum logic [2:0] {
		ST_WHOLE     = 3'd0,
		ST_OPENED    = 3'd1,
		ST_SHORT     = 3'd2,
		ST_APPENDED  = 3'd3,
		ST_COMPLETED = 3'd4,
		ST_IGNORED   = 3'd5,
		ST_DROPPED   = 3'd6
	} status_t;

	typedef struct packed {
		logic [31:0] version;
		logic [31:0] tick;
		logic [31:0] cfg_id;
		logic [31:0] message;
		logic [7:0]  kind;
		logic [7:0]  format;
		logic [15:0] samples;
		logic [7:0]  elem_size;
	} hdr_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             is_cmd;
		hdr_t             hdr;
	} parse_t;

	typedef struct packed {
		status_t          status;
		logic             hdr_valid;
		logic [ASM_W-1:0] assembled;
		logic [TGT_W-1:0] expected;
		hdr_t             hdr;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = MAGIC_C;
			2'd1: m = MAGIC_M;
			2'd2: m = MAGIC_D;
			default: m = MAGIC_COLON;
		endcase
		return m;
	endfunction

endpackage

FILE: design/fra_parse.sv
// byte position, magic detection and header field capture
module fra_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [fra_pkg::DATA_W-1:0] data_byte,
	input  logic                      frag_first,
	input  logic                      frag_last,
	output fra_pkg::parse_t           info
);

	localparam int WI_W = fra_pkg::POS_W - 2;
	localparam logic [WI_W-1:0] VER_WORD = WI_W'(1);
	localparam logic [WI_W-1:0] TICK_WORD = WI_W'(5);
	localparam logic [WI_W-1:0] CFG_WORD = WI_W'(6);
	localparam logic [WI_W-1:0] MSG_WORD = WI_W'(7);
	localparam logic [fra_pkg::POS_W-1:0] KIND_POS = fra_pkg::POS_W'(32);
	localparam logic [fra_pkg::POS_W-1:0] FMT_POS = fra_pkg::POS_W'(33);
	localparam logic [fra_pkg::POS_W-1:0] SMP_LO_POS = fra_pkg::POS_W'(34);
	localparam logic [fra_pkg::POS_W-1:0] SMP_HI_POS = fra_pkg::POS_W'(35);
	localparam logic [fra_pkg::POS_W-1:0] ELEM_POS = fra_pkg::POS_W'(36);
	localparam logic [fra_pkg::POS_W-1:0] MAGIC_END = fra_pkg::POS_W'(3);

	logic [fra_pkg::POS_W-1:0] pos_q, pos_n, p;
	logic                      magic_q, magic_n, hit;
	fra_pkg::hdr_t             hdr_q, hdr_n;
	logic [4:0]                sh;

	always_comb begin
		p = frag_first ? '0 : pos_q;
		magic_n = magic_q;
		hdr_n = hdr_q;
		hit = (data_byte == fra_pkg::magic_byte(p[1:0]));
		sh = {p[1:0], 3'b000};
		if (p <= MAGIC_END) begin
			magic_n = (p == '0) ? hit : (magic_q && hit);
			if (p == MAGIC_END && magic_n) begin
				hdr_n = '0;
			end
		end else if (magic_q) begin
			if (p[fra_pkg::POS_W-1:2] == VER_WORD) begin
				hdr_n.version[sh +: 8] = data_byte;
			end else if (p[fra_pkg::POS_W-1:2] == TICK_WORD) begin
				hdr_n.tick[sh +: 8] = data_byte;
			end else if (p[fra_pkg::POS_W-1:2] == CFG_WORD) begin
				hdr_n.cfg_id[sh +: 8] = data_byte;
			end else if (p[fra_pkg::POS_W-1:2] == MSG_WORD) begin
				hdr_n.message[sh +: 8] = data_byte;
			end else if (p == KIND_POS) begin
				hdr_n.kind = data_byte;
			end else if (p == FMT_POS) begin
				hdr_n.format = data_byte;
			end else if (p == SMP_LO_POS) begin
				hdr_n.samples[7:0] = data_byte;
			end else if (p == SMP_HI_POS) begin
				hdr_n.samples[15:8] = data_byte;
			end else if (p == ELEM_POS) begin
				hdr_n.elem_size = data_byte;
			end
		end
		if (frag_last) begin
			pos_n = '0;
		end else if (p < fra_pkg::POS_MAX) begin
			pos_n = p + 1'b1;
		end else begin
			pos_n = fra_pkg::POS_MAX;
		end
		info.pos = p;
		info.is_cmd = magic_n && (p >= MAGIC_END);
		info.hdr = hdr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			magic_q <= 1'b0;
			hdr_q <= '0;
		end else if (en) begin
			pos_q <= pos_n;
			magic_q <= magic_n;
			hdr_q <= hdr_n;
		end
	end

endmodule

FILE: design/fra_track.sv
// packet length tracking and per-fragment status
module fra_track #(
	parameter int unsigned BUFFER_BYTES = fra_pkg::DEFAULT_BUFFER_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fra_pkg::parse_t info,
	output fra_pkg::res_t   res
);

	localparam int RUN_W = $clog2(BUFFER_BYTES + 1);
	localparam int SUM_W = ((RUN_W > fra_pkg::LEN_W) ? RUN_W : fra_pkg::LEN_W) + 1;
	localparam int CMP_W = (SUM_W > fra_pkg::TGT_W) ? SUM_W : fra_pkg::TGT_W;
	localparam logic [CMP_W-1:0] BUF_LIM = CMP_W'(BUFFER_BYTES);

	logic                      open_q, open_n;
	logic [RUN_W-1:0]          run_q, run_n;
	logic [fra_pkg::TGT_W-1:0] tgt_q, tgt_n, tgt_new;
	logic [fra_pkg::LEN_W-1:0] len;
	logic [SUM_W-1:0]          sum;
	logic [fra_pkg::TGT_W-1:0] product;
	logic                      hv;
	logic [fra_pkg::TGT_W-1:0] expected;
	fra_pkg::status_t          status;

	always_comb begin
		len = fra_pkg::LEN_W'(info.pos) + 1'b1;
		product = fra_pkg::TGT_W'(info.hdr.samples) * fra_pkg::TGT_W'(info.hdr.elem_size);
		tgt_new = product + fra_pkg::TGT_W'(fra_pkg::FULL_HDR_BYTES);
		sum = SUM_W'(run_q) + SUM_W'(len);
		open_n = open_q;
		run_n = run_q;
		tgt_n = tgt_q;
		hv = 1'b0;
		expected = '0;
		status = fra_pkg::ST_IGNORED;
		if (info.is_cmd) begin
			open_n = 1'b0;
			run_n = '0;
			hv = (len >= fra_pkg::HDR_MIN_BYTES);
			if (CMP_W'(len) <= BUF_LIM) begin
				run_n = RUN_W'(len);
				if (len >= fra_pkg::FULL_HDR_BYTES) begin
					tgt_n = tgt_new;
					expected = tgt_new;
					if (CMP_W'(len) < CMP_W'(tgt_new)) begin
						open_n = 1'b1;
						status = fra_pkg::ST_OPENED;
					end else begin
						status = fra_pkg::ST_WHOLE;
					end
				end else begin
					status = fra_pkg::ST_SHORT;
				end
			end else begin
				status = fra_pkg::ST_DROPPED;
			end
		end else if (open_q && (run_q != '0)) begin
			if (CMP_W'(sum) <= BUF_LIM) begin
				run_n = RUN_W'(sum);
				hv = 1'b1;
				expected = tgt_q;
				if (CMP_W'(sum) >= CMP_W'(tgt_q)) begin
					open_n = 1'b0;
					status = fra_pkg::ST_COMPLETED;
				end else begin
					status = fra_pkg::ST_APPENDED;
				end
			end else begin
				status = fra_pkg::ST_DROPPED;
			end
		end
		res.status = status;
		res.hdr_valid = hv;
		res.assembled = fra_pkg::ASM_W'(run_n);
		res.expected = expected;
		res.hdr = hv ? info.hdr : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			run_q <= '0;
			tgt_q <= '0;
		end else if (en) begin
			open_q <= open_n;
			run_q <= run_n;
			tgt_q <= tgt_n;
		end
	end

endmodule

FILE: design/fragment_reassembly_deframer.sv
// top level of the fragment reassembly deframer
//
// slave stream: one fragment byte per transaction in s_axis_tdata, tuser marks
// the first byte of a fragment, tlast marks its last byte. master stream: one
// transaction per fragment, issued for its last byte, with status, lengths and
// the captured header in m_axis_tdata and header_valid in m_axis_tuser.
// bytes pass an input register, then the combinational parse and length logic
// (byte position, magic, header capture, 16x8 length multiply and compares)
// into the result register, which takes the result when a last byte leaves the
// input register; one byte is accepted every cycle unless the input stalls.
// non-last bytes never wait on the master side; a last byte waits in the input
// register only while the result register holds a result the receiver has not
// taken, and the input stalls behind it. the result register keeps its data
// stable while m_axis_tready is low.
// reset clears byte position, magic state, open packet, lengths and header,
// and empties both registers.
module fragment_reassembly_deframer #(
	parameter int unsigned BUFFER_BYTES = fra_pkg::DEFAULT_BUFFER_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [fra_pkg::DATA_W-1:0]  s_axis_tdata,  // data_byte
	input  logic                        s_axis_tlast,  // frag_last
	input  logic                        s_axis_tuser,  // frag_first
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// status, assembled_length, expected_length, version_code, tick_value,
	// config_ident, message_ident, packet_kind, packet_format, sample_count,
	// element_bytes, zero fill
	output logic [fra_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tuser   // header_valid
);

	logic                       valid_s1;
	logic [fra_pkg::DATA_W-1:0] byte_s1;
	logic                       first_s1;
	logic                       last_s1;
	logic                       adv;
	logic                       m_valid_q;
	fra_pkg::res_t              res_q;
	fra_pkg::res_t              res;
	fra_pkg::parse_t            info;

	assign adv = valid_s1 && (!last_s1 || !m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	fra_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.data_byte  (byte_s1),
		.frag_first (first_s1),
		.frag_last  (last_s1),
		.info       (info)
	);

	fra_track #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv && last_s1),
		.info   (info),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser = res_q.hdr_valid;
	assign m_axis_tdata = {
		7'b0,
		res_q.hdr.elem_size,
		res_q.hdr.samples,
		res_q.hdr.format,
		res_q.hdr.kind,
		res_q.hdr.message,
		res_q.hdr.cfg_id,
		res_q.hdr.tick,
		res_q.hdr.version,
		res_q.expected,
		res_q.assembled,
		res_q.status
	};

	a_open_has_header: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (res_q.status == fra_pkg::ST_OPENED ||
			res_q.status == fra_pkg::ST_APPENDED ||
			res_q.status == fra_pkg::ST_COMPLETED)) |-> res_q.hdr_valid)
		else $error("open packet status without header");

	a_ignored_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.status == fra_pkg::ST_IGNORED) |->
			(!res_q.hdr_valid && res_q.expected == '0))
		else $error("ignored fragment reports header or length");

	a_no_header_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !res_q.hdr_valid) |-> (res_q.hdr == '0))
		else $error("header fields set without header_valid");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last_s1) |=> (m_valid_q == $past(m_valid_q && !m_axis_tready)))
		else $error("result produced by a byte that is not last");

endmodule

FILE: sim/tb_fragment_reassembly_deframer.sv
// testbench for the fragment reassembly deframer: directed table, random fragments, scoreboard
`timescale 1ns / 100ps

module tb_fragment_reassembly_deframer;

	localparam int unsigned BUF_BYTES = fra_pkg::DEFAULT_BUFFER_BYTES;
	localparam logic [31:0] CMD_TAG = {fra_pkg::MAGIC_COLON, fra_pkg::MAGIC_D,
		fra_pkg::MAGIC_M, fra_pkg::MAGIC_C};
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BYTES = 1500;

	// field offsets in m_axis_tdata
	localparam int O_ST = 0;
	localparam int O_ASM = 3;
	localparam int O_EXP = 17;
	localparam int O_VER = 41;
	localparam int O_TICK = 73;
	localparam int O_CFG = 105;
	localparam int O_MSG = 137;
	localparam int O_KIND = 169;
	localparam int O_FMT = 177;
	localparam int O_SAMP = 185;
	localparam int O_ELEM = 201;

	typedef enum int {FRAG_RAW, FRAG_CMD, FRAG_BAD_TAG} frag_kind_t;

	typedef struct {
		bit               on;
		fra_pkg::status_t st;
		bit               hv;
		int unsigned      asm_len;
		int unsigned      exp_len;
	} pin_t;

	typedef struct {
		frag_kind_t  kind;
		int          len;
		bit          no_first;
		int          restart_at;
		logic [15:0] samples;
		logic [7:0]  elem;
		bit          ones;
		pin_t        pin;
	} row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [fra_pkg::DATA_W-1:0]   s_axis_tdata;
	logic                         s_axis_tlast;
	logic                         s_axis_tuser;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [fra_pkg::TDATA_W-1:0]  m_axis_tdata;
	logic                         m_axis_tuser;

	// predictor state
	int unsigned   frag_pos;
	bit            tag_ok;
	bit            pkt_open;
	int unsigned   run_len;
	int unsigned   tgt_len;
	fra_pkg::hdr_t hdr_cap;

	fra_pkg::res_t report_q[$];
	pin_t          pinned_q[$];
	int            mismatches;
	int            stuck;
	bit            calm;
	bit            hold_req;

	fra_pkg::res_t want_rep;
	fra_pkg::res_t got_rep;
	pin_t          pin;

	row_t plan[23];

	fragment_reassembly_deframer #(
		.BUFFER_BYTES(BUF_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit deframe_byte(input logic [7:0] b, input logic first,
			input logic last, output fra_pkg::res_t rep);
		int unsigned p;
		int unsigned len;
		int unsigned want_len;
		int unsigned s;
		int unsigned e;
		bit cmd;
		bit hv;
		fra_pkg::status_t st;
		rep = '0;
		p = first ? 0 : frag_pos;
		if (p < 4) begin
			tag_ok = (b == CMD_TAG[8*p +: 8]) && (p == 0 || tag_ok);
			if (p == 3 && tag_ok)
				hdr_cap = '0;
		end else if (tag_ok) begin
			case (p)
				4, 5, 6, 7: hdr_cap.version[8*(p-4) +: 8] = b;
				20, 21, 22, 23: hdr_cap.tick[8*(p-20) +: 8] = b;
				24, 25, 26, 27: hdr_cap.cfg_id[8*(p-24) +: 8] = b;
				28, 29, 30, 31: hdr_cap.message[8*(p-28) +: 8] = b;
				32: hdr_cap.kind = b;
				33: hdr_cap.format = b;
				34: hdr_cap.samples[7:0] = b;
				35: hdr_cap.samples[15:8] = b;
				36: hdr_cap.elem_size = b;
				default: ;
			endcase
		end
		if (!last) begin
			frag_pos = (p < fra_pkg::POS_MAX) ? p + 1 : fra_pkg::POS_MAX;
			return 1'b0;
		end
		frag_pos = 0;
		len = p + 1;
		cmd = tag_ok && p >= 3;
		hv = 1'b0;
		want_len = 0;
		if (cmd) begin
			pkt_open = 1'b0;
			run_len = 0;
			hv = len >= fra_pkg::HDR_MIN_BYTES;
			if (len <= BUF_BYTES) begin
				run_len = len;
				if (len >= fra_pkg::FULL_HDR_BYTES) begin
					s = hdr_cap.samples;
					e = hdr_cap.elem_size;
					tgt_len = fra_pkg::FULL_HDR_BYTES + s * e;
					want_len = tgt_len;
					pkt_open = len < tgt_len;
					if (pkt_open)
						st = fra_pkg::ST_OPENED;
					else
						st = fra_pkg::ST_WHOLE;
				end else begin
					st = fra_pkg::ST_SHORT;
				end
			end else begin
				st = fra_pkg::ST_DROPPED;
			end
		end else if (pkt_open && run_len > 0) begin
			if (run_len + len <= BUF_BYTES) begin
				run_len += len;
				hv = 1'b1;
				want_len = tgt_len;
				pkt_open = run_len < tgt_len;
				if (pkt_open)
					st = fra_pkg::ST_APPENDED;
				else
					st = fra_pkg::ST_COMPLETED;
			end else begin
				st = fra_pkg::ST_DROPPED;
			end
		end else begin
			st = fra_pkg::ST_IGNORED;
		end
		rep.status = st;
		rep.hdr_valid = hv;
		rep.assembled = run_len[fra_pkg::ASM_W-1:0];
		rep.expected = want_len[fra_pkg::TGT_W-1:0];
		rep.hdr = hv ? hdr_cap : '0;
		return 1'b1;
	endfunction

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic fra_pkg::hdr_t random_header(input logic [15:0] samples,
			input logic [7:0] elem);
		fra_pkg::hdr_t h;
		h.version = $urandom;
		h.tick = $urandom;
		h.cfg_id = $urandom;
		h.message = $urandom;
		h.kind = 8'($urandom);
		h.format = 8'($urandom);
		h.samples = samples;
		h.elem_size = elem;
		return h;
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic send_byte(input logic [7:0] d, input logic first, input logic last);
		int g;
		g = idle_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= first;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_fragment(input frag_kind_t kind, input int len, input fra_pkg::hdr_t h,
			input bit no_first, input int restart_at, input pin_t pn);
		int i;
		int bad;
		logic [7:0] b;
		bad = $urandom_range(0, 3);
		pinned_q.push_back(pn);
		for (i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (kind != FRAG_RAW) begin
				case (i)
					0, 1, 2, 3: begin
						b = CMD_TAG[8*i +: 8];
						if (kind == FRAG_BAD_TAG && i == bad)
							b = b ^ (8'h01 << $urandom_range(0, 7));
					end
					4, 5, 6, 7: b = h.version[8*(i-4) +: 8];
					20, 21, 22, 23: b = h.tick[8*(i-20) +: 8];
					24, 25, 26, 27: b = h.cfg_id[8*(i-24) +: 8];
					28, 29, 30, 31: b = h.message[8*(i-28) +: 8];
					32: b = h.kind;
					33: b = h.format;
					34: b = h.samples[7:0];
					35: b = h.samples[15:8];
					36: b = h.elem_size;
					default: ;
				endcase
			end
			send_byte(b, (i == 0) ? !no_first : (i == restart_at), i == len - 1);
		end
	endtask

	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (report_q.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (deframe_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, want_rep)) begin
					if (pinned_q.size() != 0) begin
						pin = pinned_q.pop_front();
						if (pin.on) begin
							want_rep.status = pin.st;
							want_rep.hdr_valid = pin.hv;
							want_rep.assembled = pin.asm_len[fra_pkg::ASM_W-1:0];
							want_rep.expected = pin.exp_len[fra_pkg::TGT_W-1:0];
						end
					end
					report_q.push_back(want_rep);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_rep.status = fra_pkg::status_t'(m_axis_tdata[O_ST +: 3]);
				got_rep.hdr_valid = m_axis_tuser;
				got_rep.assembled = m_axis_tdata[O_ASM +: fra_pkg::ASM_W];
				got_rep.expected = m_axis_tdata[O_EXP +: fra_pkg::TGT_W];
				got_rep.hdr.version = m_axis_tdata[O_VER +: 32];
				got_rep.hdr.tick = m_axis_tdata[O_TICK +: 32];
				got_rep.hdr.cfg_id = m_axis_tdata[O_CFG +: 32];
				got_rep.hdr.message = m_axis_tdata[O_MSG +: 32];
				got_rep.hdr.kind = m_axis_tdata[O_KIND +: 8];
				got_rep.hdr.format = m_axis_tdata[O_FMT +: 8];
				got_rep.hdr.samples = m_axis_tdata[O_SAMP +: 16];
				got_rep.hdr.elem_size = m_axis_tdata[O_ELEM +: 8];
				if (report_q.size() == 0) begin
					$error("result transaction with no expected report, status %0d",
						m_axis_tdata[O_ST +: 3]);
					mismatches++;
				end else begin
					want_rep = report_q.pop_front();
					cmp_field("status", want_rep.status, got_rep.status);
					cmp_field("header_valid", want_rep.hdr_valid, got_rep.hdr_valid);
					cmp_field("assembled_length", want_rep.assembled, got_rep.assembled);
					cmp_field("expected_length", want_rep.expected, got_rep.expected);
					cmp_field("version_code", want_rep.hdr.version, got_rep.hdr.version);
					cmp_field("tick_value", want_rep.hdr.tick, got_rep.hdr.tick);
					cmp_field("config_ident", want_rep.hdr.cfg_id, got_rep.hdr.cfg_id);
					cmp_field("message_ident", want_rep.hdr.message, got_rep.hdr.message);
					cmp_field("packet_kind", want_rep.hdr.kind, got_rep.hdr.kind);
					cmp_field("packet_format", want_rep.hdr.format, got_rep.hdr.format);
					cmp_field("sample_count", want_rep.hdr.samples, got_rep.hdr.samples);
					cmp_field("element_bytes", want_rep.hdr.elem_size, got_rep.hdr.elem_size);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck <= 0;
		end else if (stuck >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	initial begin : sink
		int g;
		m_axis_tready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			g = idle_len();
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	initial begin : source
		int i;
		int len;
		int r;
		int q;
		int nfrag;
		int sent;
		int owed;
		int tgt;
		int restart_at;
		bit no_first;
		frag_kind_t kind;
		fra_pkg::hdr_t h;
		pin_t free_pin;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		s_axis_tuser <= 1'b0;
		mismatches = 0;
		stuck = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		frag_pos = 0;
		tag_ok = 1'b0;
		pkt_open = 1'b0;
		run_len = 0;
		tgt_len = 0;
		hdr_cap = '0;
		free_pin = '{1'b0, fra_pkg::ST_WHOLE, 1'b0, 0, 0};

		plan = '{
			'{FRAG_RAW, 5, 0, -1, 16'h0, 8'h0, 0, '{1, fra_pkg::ST_IGNORED, 0, 0, 0}},
			'{FRAG_CMD, 3, 0, -1, 16'h0, 8'h0, 0, '{1, fra_pkg::ST_IGNORED, 0, 0, 0}},
			'{FRAG_CMD, 4, 0, -1, 16'h0, 8'h0, 0, '{1, fra_pkg::ST_SHORT, 0, 4, 0}},
			'{FRAG_CMD, 33, 0, -1, 16'h0, 8'h0, 1, '{1, fra_pkg::ST_SHORT, 0, 33, 0}},
			'{FRAG_CMD, 34, 0, -1, 16'hffff, 8'hff, 1, '{1, fra_pkg::ST_SHORT, 1, 34, 0}},
			'{FRAG_RAW, 2, 0, -1, 16'h0, 8'h0, 0, '{1, fra_pkg::ST_IGNORED, 0, 34, 0}},
			'{FRAG_CMD, 37, 0, -1, 16'h0, 8'h0, 1, '{1, fra_pkg::ST_WHOLE, 1, 37, 37}},
			'{FRAG_CMD, 37, 0, -1, 16'hffff, 8'hff, 1,
				'{1, fra_pkg::ST_OPENED, 1, 37, 16711462}},
			'{FRAG_RAW, 8200, 0, -1, 16'h0, 8'h0, 0, '{1, fra_pkg::ST_DROPPED, 0, 37, 0}},
			'{FRAG_RAW, 100, 0, -1, 16'h0, 8'h0, 0,
				'{1, fra_pkg::ST_APPENDED, 1, 137, 16711462}},
			'{FRAG_CMD, 40, 0, -1, 16'd3, 8'd10, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_RAW, 10, 1, -1, 16'h0, 8'h0, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_RAW, 30, 0, -1, 16'h0, 8'h0, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_RAW, 5, 0, -1, 16'h0, 8'h0, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_BAD_TAG, 40, 0, -1, 16'd1, 8'd1, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_CMD, 8193, 0, -1, 16'h10, 8'd2, 0, '{1, fra_pkg::ST_DROPPED, 1, 0, 0}},
			'{FRAG_CMD, 8192, 0, -1, 16'h100, 8'h40, 0,
				'{1, fra_pkg::ST_OPENED, 1, 8192, 16421}},
			'{FRAG_RAW, 1, 0, -1, 16'h0, 8'h0, 0, '{1, fra_pkg::ST_DROPPED, 0, 8192, 0}},
			'{FRAG_CMD, 16400, 0, -1, 16'd5, 8'd5, 0, '{1, fra_pkg::ST_DROPPED, 1, 0, 0}},
			'{FRAG_CMD, 50, 0, 10, 16'd2, 8'd2, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_CMD, 37, 0, -1, 16'd1, 8'd1, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_RAW, 1, 0, -1, 16'h0, 8'h0, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}},
			'{FRAG_CMD, 60, 1, -1, 16'd2, 8'd5, 0, '{0, fra_pkg::ST_WHOLE, 0, 0, 0}}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(plan); i++) begin
			h = random_header(plan[i].samples, plan[i].elem);
			if (plan[i].ones) begin
				h = '1;
				h.samples = plan[i].samples;
				h.elem_size = plan[i].elem;
			end
			send_fragment(plan[i].kind, plan[i].len, h, plan[i].no_first,
				plan[i].restart_at, plan[i].pin);
		end
		wait_results();

		// random fragments, opening with a long receiver stall on short ones
		hold_req = 1'b1;
		nfrag = 0;
		sent = 0;
		owed = 0;
		while (sent < RANDOM_BYTES || nfrag < 80) begin
			if (nfrag == 60)
				wait_results();
			calm = nfrag >= 40 && nfrag < 55;
			no_first = $urandom_range(0, 4) == 0;
			r = $urandom_range(0, 99);
			h = random_header(16'($urandom_range(0, 20)), 8'($urandom_range(0, 6)));
			if ($urandom_range(0, 6) == 0)
				h = random_header(16'($urandom), 8'($urandom));
			if (nfrag < 30) begin
				kind = frag_kind_t'($urandom_range(0, 2));
				len = $urandom_range(1, 6);
			end else if (owed > 0 && r < 70) begin
				kind = FRAG_RAW;
				if (r < 42)
					len = $urandom_range(1, (owed < 40) ? owed : 40);
				else
					len = $urandom_range(1, 60);
			end else if (r < 75) begin
				kind = FRAG_CMD;
				q = $urandom_range(0, 19);
				if (q < 15)
					len = $urandom_range(37, 90);
				else if (q < 19)
					len = $urandom_range(1, 36);
				else
					len = $urandom_range(91, 300);
			end else if (r < 88) begin
				kind = FRAG_RAW;
				len = $urandom_range(1, 20);
			end else begin
				kind = FRAG_BAD_TAG;
				len = $urandom_range(4, 50);
			end
			restart_at = -1;
			if (len > 1 && $urandom_range(0, 19) == 0)
				restart_at = $urandom_range(1, len - 1);
			send_fragment(kind, len, h, no_first, restart_at, free_pin);
			if (kind == FRAG_CMD && len >= 37) begin
				tgt = 37 + h.samples * h.elem_size;
				owed = (len < tgt) ? tgt - len : 0;
			end else if (kind == FRAG_CMD && len >= 4) begin
				owed = 0;
			end else if (len >= owed) begin
				owed = 0;
			end else begin
				owed -= len;
			end
			sent += len;
			nfrag++;
		end
		calm = 1'b0;

		wait_results();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
design/fra_pkg.sv
design/fra_parse.sv
design/fra_track.sv
design/fragment_reassembly_deframer.sv
sim/tb_fragment_reassembly_deframer.sv
